### hdl/byte_range_lock_table_top_defines.svh
// Assertion macros for the byte-range lock table.
`ifndef BYTE_RANGE_LOCK_TABLE_TOP_DEFINES_SVH
`define BYTE_RANGE_LOCK_TABLE_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BRL_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define BRL_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### hdl/brlt_pkg.sv
// Shared types and constants for the byte-range lock table.
`timescale 1ns / 1ps
`default_nettype none
package brlt_pkg;
    localparam logic [2:0] OP_TEST      = 3'd0;
    localparam logic [2:0] OP_ACQUIRE   = 3'd1;
    localparam logic [2:0] OP_RELEASE   = 3'd2;
    localparam logic [2:0] OP_REL_OWNER = 3'd3;
    localparam logic [2:0] OP_REL_FILE  = 3'd4;
    localparam logic [2:0] OP_HAS_LOCKS = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic start_scan;   // reset index and scan summaries
        logic step;         // advance one slot
        logic apply;        // second pass: write changes for the current slot
        logic place;        // write next pending remnant to the free slot
        logic rescan;       // drop the free slot found so far before placing remnants
        logic grant;        // write acquire into the free slot
        logic load;         // capture the request
    } brlt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;         // current index is the last slot
        logic conflict;     // a conflict was found in the scan
        logic have_free;    // a free slot exists
        logic rel_full;     // release needs more free slots than are available
        logic pend_left;    // remnants still to place
    } brlt_sts_t;
endpackage
`default_nettype wire

### hdl/brlt_datapath.sv
// Slot store, request registers and per-slot scan logic.
`timescale 1ns / 1ps
`default_nettype none
module brlt_datapath
    import brlt_pkg::*;
#(
    parameter int NUM_SLOTS = 64,
    parameter int ID_BITS   = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire brlt_cmd_t             cmd,
    output brlt_sts_t                  sts,
    input  wire logic [2:0]            opcode,
    input  wire logic [31:0]           file_id,
    input  wire logic [31:0]           owner_id,
    input  wire logic                  want_exclusive,
    input  wire logic [63:0]           range_start,
    input  wire logic [63:0]           range_length,
    output logic [2:0]                 op_q,
    output logic [63:0]                c_start,
    output logic [63:0]                c_length,
    output logic                       c_excl,
    output logic [31:0]                c_owner,
    output logic                       holds
);
    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int IDW = (ID_BITS < 32) ? ID_BITS : 32;

    typedef struct packed {
        logic [IDW-1:0] file;
        logic [IDW-1:0] owner;
        logic [63:0]    start;
        logic [63:0]    len;
        logic           excl;
    } slot_t;

    // pending right remnant (file/owner equal to the request's)
    typedef struct packed {
        logic [63:0] start;
        logic [63:0] len;
        logic        excl;
    } rem_t;

    logic [NUM_SLOTS-1:0] valid_reg;
    slot_t slot_mem [NUM_SLOTS];
    slot_t rd_reg;
    rem_t rem_mem [NUM_SLOTS];
    rem_t rem_rd_reg;

    logic [2:0] op_reg;
    logic [IDW-1:0] f_reg, o_reg;
    logic ex_reg;
    logic [63:0] rs_reg, rl_reg, rend_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] nfree_reg, nsplit_reg, npend_reg, nplace_reg;
    logic conf_reg, free_ok_reg, holds_reg;
    logic [IW-1:0] free_reg;
    logic [63:0] cs_reg, cl_reg;
    logic ce_reg;
    logic [IDW-1:0] co_reg;

    logic [IDW-1:0] cur_f, cur_o;
    logic [63:0] cur_s, cur_l, cur_e, rl_in_e, rem_len;
    logic [64:0] sum;
    logic cur_v, cur_x, same_fo, ovl, is_conf, lft, rgt, is_last;

    logic wr_en, rem_we;
    logic [IW-1:0] wr_addr;
    slot_t wr_data;
    rem_t rem_wdata;

    always_comb
    begin
        cur_v = valid_reg[idx_reg];
        cur_f = rd_reg.file;
        cur_o = rd_reg.owner;
        cur_s = rd_reg.start;
        cur_l = rd_reg.len;
        cur_x = rd_reg.excl;
        sum = {1'b0, cur_s} + {1'b0, cur_l};
        cur_e = (cur_l == ALL_ONES || sum[64]) ? ALL_ONES : sum[63:0];
        ovl = (rs_reg < cur_e) && (cur_s < rend_reg);
        same_fo = cur_v && cur_f == f_reg && cur_o == o_reg;
        is_conf = cur_v && cur_f == f_reg && cur_o != o_reg && (ex_reg || cur_x) && ovl;
        lft = cur_s < rs_reg;
        rgt = cur_e > rend_reg && rend_reg != ALL_ONES;
        rem_len = (cur_l == ALL_ONES) ? ALL_ONES : cur_e - rend_reg;
        is_last = (idx_reg == IW'(NUM_SLOTS - 1));
    end

    logic [64:0] rsum;
    always_comb
    begin
        rsum = {1'b0, range_start} + {1'b0, range_length};
        rl_in_e = (range_length == ALL_ONES || rsum[64]) ? ALL_ONES : rsum[63:0];
    end

    always_comb
    begin
        if (cmd.start_scan || cmd.place)
            idx_next = '0;
        else if (cmd.step)
            idx_next = is_last ? '0 : idx_reg + IW'(1);
        else
            idx_next = idx_reg;
    end

    // single write port into the slot store
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_reg;
        if (cmd.grant)
        begin
            wr_en = 1'b1;
            wr_addr = free_reg;
            wr_data.file = f_reg;
            wr_data.owner = o_reg;
            wr_data.start = rs_reg;
            wr_data.len = rl_reg;
            wr_data.excl = ex_reg;
        end
        else if (cmd.place)
        begin
            wr_en = 1'b1;
            wr_addr = free_reg;
            wr_data.file = f_reg;
            wr_data.owner = o_reg;
            wr_data.start = rem_rd_reg.start;
            wr_data.len = rem_rd_reg.len;
            wr_data.excl = rem_rd_reg.excl;
        end
        else if (cmd.step && cmd.apply && op_reg == OP_RELEASE && same_fo && ovl)
        begin
            wr_en = lft || rgt;
            if (lft)
                wr_data.len = rs_reg - cur_s;
            else
            begin
                wr_data.start = rend_reg;
                wr_data.len = rem_len;
            end
        end
    end

    always_comb
    begin
        rem_we = cmd.step && cmd.apply && op_reg == OP_RELEASE && same_fo && ovl && lft && rgt;
        rem_wdata.start = rend_reg;
        rem_wdata.len = rem_len;
        rem_wdata.excl = cur_x;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        rd_reg <= slot_mem[idx_next];
    end

    always_ff @(posedge clk)
    begin
        if (rem_we)
            rem_mem[npend_reg[IW-1:0]] <= rem_wdata;
        rem_rd_reg <= rem_mem[nplace_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            idx_reg <= '0;
            nfree_reg <= '0;
            nsplit_reg <= '0;
            npend_reg <= '0;
            nplace_reg <= '0;
            conf_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            holds_reg <= 1'b0;
            op_reg <= '0;
            f_reg <= '0;
            o_reg <= '0;
            ex_reg <= 1'b0;
            rs_reg <= '0;
            rl_reg <= '0;
            rend_reg <= '0;
            free_reg <= '0;
            cs_reg <= '0;
            cl_reg <= '0;
            ce_reg <= 1'b0;
            co_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                op_reg <= opcode;
                f_reg <= file_id[IDW-1:0];
                o_reg <= owner_id[IDW-1:0];
                ex_reg <= want_exclusive;
                rs_reg <= range_start;
                rl_reg <= range_length;
                rend_reg <= rl_in_e;
            end
            if (cmd.start_scan)
            begin
                nfree_reg <= '0;
                nsplit_reg <= '0;
                npend_reg <= '0;
                nplace_reg <= '0;
                conf_reg <= 1'b0;
                free_ok_reg <= 1'b0;
                holds_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                if (!cur_v)
                begin
                    nfree_reg <= nfree_reg + CW'(1);
                    if (!free_ok_reg && !cmd.apply)
                    begin
                        free_ok_reg <= 1'b1;
                        free_reg <= idx_reg;
                    end
                end
                if (same_fo)
                begin
                    holds_reg <= 1'b1;
                    if (ovl)
                    begin
                        if (!lft && !rgt)
                            nfree_reg <= nfree_reg + CW'(1);
                        else if (lft && rgt)
                            nsplit_reg <= nsplit_reg + CW'(1);
                    end
                end
                if (is_conf && !conf_reg)
                begin
                    conf_reg <= 1'b1;
                    cs_reg <= cur_s;
                    cl_reg <= cur_l;
                    ce_reg <= cur_x;
                    co_reg <= cur_o;
                end
                if (cmd.apply)
                begin
                    case (op_reg)
                        OP_RELEASE:
                        begin
                            if (same_fo && ovl && !lft && !rgt)
                                valid_reg[idx_reg] <= 1'b0;
                            if (rem_we)
                                npend_reg <= npend_reg + CW'(1);
                        end
                        OP_REL_OWNER:
                            if (cur_v && cur_o == o_reg)
                                valid_reg[idx_reg] <= 1'b0;
                        OP_REL_FILE:
                            if (same_fo)
                                valid_reg[idx_reg] <= 1'b0;
                        default: ;
                    endcase
                end
            end
            if (cmd.rescan)
                free_ok_reg <= 1'b0;
            if (cmd.grant)
                valid_reg[free_reg] <= 1'b1;
            if (cmd.place)
            begin
                // free_reg found by the rescan preceding this write
                valid_reg[free_reg] <= 1'b1;
                nplace_reg <= nplace_reg + CW'(1);
                free_ok_reg <= 1'b0;
            end
        end
    end

    assign sts.last = is_last;
    assign sts.conflict = conf_reg;
    assign sts.have_free = free_ok_reg;
    assign sts.rel_full = nsplit_reg > nfree_reg;
    assign sts.pend_left = nplace_reg < npend_reg;

    assign op_q = op_reg;
    assign c_start = cs_reg;
    assign c_length = cl_reg;
    assign c_excl = ce_reg;
    assign c_owner = 32'(co_reg);
    assign holds = holds_reg;
endmodule
`default_nettype wire

### hdl/brlt_ctrl.sv
// Operation sequencer: scan passes, writes and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module brlt_ctrl
    import brlt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire logic [2:0] op_q,
    input  wire brlt_sts_t  sts,
    output brlt_cmd_t       cmd,
    output logic [1:0]      status_q
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_APPLY = 7'b0001000,
        S_FIND  = 7'b0010000,
        S_PLACE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] status_reg, status_next;

    always_comb
    begin
        state_next = state_reg;
        status_next = status_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.start_scan = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.last)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // scan summaries now include the last slot
                state_next = S_DONE;
                status_next = ST_OK;
                case (op_q)
                    OP_TEST:
                        if (sts.conflict) status_next = ST_CONFLICT;
                    OP_ACQUIRE:
                        if (sts.conflict) status_next = ST_CONFLICT;
                        else if (!sts.have_free) status_next = ST_FULL;
                        else cmd.grant = 1'b1;
                    OP_RELEASE:
                        if (sts.rel_full) status_next = ST_FULL;
                        else state_next = S_APPLY;
                    OP_REL_OWNER, OP_REL_FILE:
                        state_next = S_APPLY;
                    default: ;
                endcase
            end
            S_APPLY:
            begin
                cmd.step = 1'b1;
                cmd.apply = 1'b1;
                if (sts.last)
                begin
                    if (op_q == OP_RELEASE)
                    begin
                        cmd.rescan = 1'b1;
                        state_next = S_FIND;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_FIND:
            begin
                // the release check guarantees a free slot for every remnant
                if (!sts.pend_left)
                    state_next = S_DONE;
                else if (sts.have_free)
                    state_next = S_PLACE;
                else
                    cmd.step = 1'b1;
            end
            S_PLACE:
            begin
                cmd.place = 1'b1;
                state_next = S_FIND;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            status_reg <= status_next;
        end
    end

    assign status_q = status_reg;
endmodule
`default_nettype wire

### hdl/byte_range_lock_table_top.sv
// Sequence: an item taken for test, acquire, has-locks or an unused opcode gets one
// scan pass over all slots and a check; the release-all opcodes add an apply pass;
// a release that fits adds the apply pass, then finds a free slot per split remnant.
// Throughput: one item at a time, set by one slot-store read per cycle; the next item
// can be taken in the cycle after the result is accepted.
// Reset: rst_n asynchronous active low clears all slot valid bits and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_range_lock_table_top_defines.svh"
module byte_range_lock_table_top
    import brlt_pkg::*;
#(
    parameter int NUM_SLOTS = 64,
    parameter int ID_BITS   = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [31:0] file_id,
    input  wire logic [31:0] owner_id,
    input  wire logic        want_exclusive,
    input  wire logic [63:0] range_start,
    input  wire logic [63:0] range_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [63:0]      conflict_start,
    output logic [63:0]      conflict_length,
    output logic             conflict_exclusive,
    output logic [31:0]      conflict_owner,
    output logic             holds_locks
);
    brlt_cmd_t cmd;
    brlt_sts_t sts;
    logic [2:0] op_q;
    logic [1:0] status_q;
    logic [63:0] cs, cl;
    logic ce, hl;
    logic [31:0] co;
    logic show_c;

    brlt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .op_q(op_q), .sts(sts),
        .cmd(cmd), .status_q(status_q)
    );

    brlt_datapath #(.NUM_SLOTS(NUM_SLOTS), .ID_BITS(ID_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .opcode(opcode),
        .file_id(file_id), .owner_id(owner_id), .want_exclusive(want_exclusive),
        .range_start(range_start), .range_length(range_length), .op_q(op_q),
        .c_start(cs), .c_length(cl), .c_excl(ce), .c_owner(co), .holds(hl)
    );

    assign show_c = (status_q == ST_CONFLICT);
    assign status = status_q;
    assign conflict_start = show_c ? cs : '0;
    assign conflict_length = show_c ? cl : '0;
    assign conflict_exclusive = show_c & ce;
    assign conflict_owner = show_c ? co : '0;
    assign holds_locks = (op_q == OP_HAS_LOCKS) & hl;

    `BRL_ASSERT_IMP(a_no_both, clk, rst_n, 1'b1, !(in_ready && out_valid))
    `BRL_ASSERT_IMP(a_status_code, clk, rst_n, out_valid,
        status == ST_OK || status == ST_CONFLICT || status == ST_FULL)
    `BRL_ASSERT_NEXT(a_take_busy, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the byte-range lock table.
`timescale 1ns / 1ps
`default_nettype none
module testbench
    import brlt_pkg::*;
();

    localparam int SLOTS = 64;
    localparam int RANDOM_ITEMS = 1810;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] file;
        logic [31:0] owner;
        logic        excl;
        logic [63:0] start;
        logic [63:0] len;
    } lock_req_t;

    typedef struct {
        logic [1:0]  st;
        logic [63:0] c_start;
        logic [63:0] c_len;
        logic        c_excl;
        logic [31:0] c_owner;
        logic        holds;
    } lock_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] opcode = '0;
    logic [31:0] file_id = '0;
    logic [31:0] owner_id = '0;
    logic want_exclusive = 1'b0;
    logic [63:0] range_start = '0;
    logic [63:0] range_length = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [63:0] conflict_start;
    logic [63:0] conflict_length;
    logic conflict_exclusive;
    logic [31:0] conflict_owner;
    logic holds_locks;

    byte_range_lock_table_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .file_id(file_id), .owner_id(owner_id),
        .want_exclusive(want_exclusive), .range_start(range_start),
        .range_length(range_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .conflict_start(conflict_start),
        .conflict_length(conflict_length), .conflict_exclusive(conflict_exclusive),
        .conflict_owner(conflict_owner), .holds_locks(holds_locks)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the lock table
    logic        lk_valid [SLOTS];
    logic [31:0] lk_file  [SLOTS];
    logic [31:0] lk_owner [SLOTS];
    logic [63:0] lk_start [SLOTS];
    logic [63:0] lk_len   [SLOTS];
    logic        lk_excl  [SLOTS];

    lock_req_t  pending_reqs[$];
    lock_resp_t expected_resps[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int n_conflict = 0;
    int n_full = 0;
    int n_split = 0;
    bit stim_done = 1'b0;
    longint cycles = 0;

    function automatic logic [63:0] end_of(logic [63:0] s, logic [63:0] l);
        logic [64:0] sum;
        if (l == ALL_ONES)
            return ALL_ONES;
        sum = {1'b0, s} + {1'b0, l};
        return sum[64] ? ALL_ONES : sum[63:0];
    endfunction

    function automatic bit spans_meet(logic [63:0] s1, logic [63:0] l1,
                                      logic [63:0] s2, logic [63:0] l2);
        return (s1 < end_of(s2, l2)) && (s2 < end_of(s1, l1));
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < SLOTS; i++)
            if (!lk_valid[i])
                return i;
        return -1;
    endfunction

    function automatic bit owned_hit(int i, lock_req_t r);
        return lk_valid[i] && lk_file[i] == r.file && lk_owner[i] == r.owner &&
               spans_meet(r.start, r.len, lk_start[i], lk_len[i]);
    endfunction

    function automatic logic [1:0] release_range(lock_req_t r);
        logic [63:0] rel_end;
        logic [63:0] se;
        logic [63:0] rem_start [$];
        logic [63:0] rem_len [$];
        logic [31:0] rem_file [$];
        logic [31:0] rem_owner [$];
        logic        rem_excl [$];
        int nfree;
        int nfreed;
        int nsplit;
        int j;
        bit lft;
        bit rgt;
        rel_end = end_of(r.start, r.len);
        nfree = 0;
        nfreed = 0;
        nsplit = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!lk_valid[i])
            begin
                nfree++;
                continue;
            end
            if (!owned_hit(i, r))
                continue;
            se = end_of(lk_start[i], lk_len[i]);
            lft = lk_start[i] < r.start;
            rgt = se > rel_end && rel_end != ALL_ONES;
            if (!lft && !rgt)
                nfreed++;
            else if (lft && rgt)
                nsplit++;
        end
        if (nsplit > nfree + nfreed)
            return ST_FULL;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!owned_hit(i, r))
                continue;
            se = end_of(lk_start[i], lk_len[i]);
            lft = lk_start[i] < r.start;
            rgt = se > rel_end && rel_end != ALL_ONES;
            if (lft)
            begin
                if (rgt)
                begin
                    rem_start = {rem_start, rel_end};
                    rem_len = {rem_len, (lk_len[i] == ALL_ONES) ? ALL_ONES : se - rel_end};
                    rem_file = {rem_file, lk_file[i]};
                    rem_owner = {rem_owner, lk_owner[i]};
                    rem_excl = {rem_excl, lk_excl[i]};
                end
                lk_len[i] = r.start - lk_start[i];
            end
            else if (rgt)
            begin
                lk_len[i] = lk_len[i] == ALL_ONES ? ALL_ONES : se - rel_end;
                lk_start[i] = rel_end;
            end
            else
                lk_valid[i] = 1'b0;
        end
        n_split += rem_start.size();
        for (int k = 0; k < rem_start.size(); k++)
        begin
            j = lowest_free();
            if (j < 0)
                break;
            lk_valid[j] = 1'b1;
            lk_file[j] = rem_file[k];
            lk_owner[j] = rem_owner[k];
            lk_start[j] = rem_start[k];
            lk_len[j] = rem_len[k];
            lk_excl[j] = rem_excl[k];
        end
        return ST_OK;
    endfunction

    function automatic lock_resp_t apply_lock_op(lock_req_t r);
        lock_resp_t p;
        int c;
        int j;
        p = '{st: ST_OK, c_start: '0, c_len: '0, c_excl: 1'b0, c_owner: '0, holds: 1'b0};
        case (r.op)
            OP_TEST, OP_ACQUIRE:
            begin
                c = -1;
                for (int i = 0; i < SLOTS && c < 0; i++)
                    if (lk_valid[i] && lk_file[i] == r.file && lk_owner[i] != r.owner &&
                        (r.excl || lk_excl[i]) &&
                        spans_meet(r.start, r.len, lk_start[i], lk_len[i]))
                        c = i;
                if (c >= 0)
                begin
                    p.st = ST_CONFLICT;
                    p.c_start = lk_start[c];
                    p.c_len = lk_len[c];
                    p.c_excl = lk_excl[c];
                    p.c_owner = lk_owner[c];
                end
                else if (r.op == OP_ACQUIRE)
                begin
                    j = lowest_free();
                    if (j < 0)
                        p.st = ST_FULL;
                    else
                    begin
                        lk_valid[j] = 1'b1;
                        lk_file[j] = r.file;
                        lk_owner[j] = r.owner;
                        lk_start[j] = r.start;
                        lk_len[j] = r.len;
                        lk_excl[j] = r.excl;
                    end
                end
            end
            OP_RELEASE:
                p.st = release_range(r);
            OP_REL_OWNER:
                for (int i = 0; i < SLOTS; i++)
                    if (lk_valid[i] && lk_owner[i] == r.owner)
                        lk_valid[i] = 1'b0;
            OP_REL_FILE:
                for (int i = 0; i < SLOTS; i++)
                    if (lk_valid[i] && lk_owner[i] == r.owner && lk_file[i] == r.file)
                        lk_valid[i] = 1'b0;
            OP_HAS_LOCKS:
                for (int i = 0; i < SLOTS; i++)
                    if (lk_valid[i] && lk_owner[i] == r.owner && lk_file[i] == r.file)
                        p.holds = 1'b1;
            default: ;
        endcase
        if (p.st == ST_CONFLICT)
            n_conflict++;
        if (p.st == ST_FULL)
            n_full++;
        return p;
    endfunction

    function automatic lock_req_t make_req(logic [2:0] op, logic [31:0] f, logic [31:0] o,
                                           logic x, logic [63:0] s, logic [63:0] l);
        lock_req_t r;
        r = '{op: op, file: f, owner: o, excl: x, start: s, len: l};
        return r;
    endfunction

    function automatic void queue_req(lock_req_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    // Small id pools so that requests collide; occasionally a wide random value.
    function automatic logic [31:0] pick_id(logic [31:0] base);
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return base + $urandom_range(0, 3);
    endfunction

    function automatic logic [63:0] pick_offset();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return ALL_ONES - 64'($urandom_range(0, 300));
            2: return 64'd0;
            default: return 64'($urandom_range(0, 400));
        endcase
    endfunction

    function automatic logic [63:0] pick_length();
        case ($urandom_range(0, 11))
            0: return ALL_ONES;
            1: return {$urandom, $urandom};
            2: return 64'd0;
            3: return ALL_ONES - 64'($urandom_range(1, 50));
            default: return 64'($urandom_range(1, 120));
        endcase
    endfunction

    function automatic lock_req_t random_req();
        int pick;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = OP_ACQUIRE;
        else if (pick < 55) op = OP_TEST;
        else if (pick < 78) op = OP_RELEASE;
        else if (pick < 82) op = OP_REL_OWNER;
        else if (pick < 87) op = OP_REL_FILE;
        else if (pick < 97) op = OP_HAS_LOCKS;
        else                op = 3'($urandom_range(6, 7));
        return make_req(op, pick_id(32'h7000_0000), pick_id(32'hA5A5_0000),
                        1'($urandom_range(0, 1)), pick_offset(), pick_length());
    endfunction

    // Driver: bursts of items with random gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || pending_reqs.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    lock_req_t r;
                    r = pending_reqs.pop_front();
                    expected_resps = {expected_resps, apply_lock_op(r)};
                    sent <= sent + 1;
                    opcode <= r.op;
                    file_id <= r.file;
                    owner_id <= r.owner;
                    want_exclusive <= r.excl;
                    range_start <= r.start;
                    range_length <= r.len;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                    end
                end
            end
        end
    end

    // Receiver: a repeating pattern of ready, mostly-ready and mostly-stalled phases
    int stall_phase = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_phase <= (stall_phase == 299) ? 0 : stall_phase + 1;
            if (stall_phase < 100)
                out_ready <= 1'b1;
            else if (stall_phase < 200)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ($urandom_range(0, 9) == 0);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            lock_resp_t e;
            received <= received + 1;
            if (expected_resps.size() == 0)
            begin
                $display("%0t unexpected result: status %0d", $realtime, status);
                errors <= errors + 1;
            end
            else
            begin
                e = expected_resps.pop_front();
                if (status !== e.st || conflict_start !== e.c_start ||
                    conflict_length !== e.c_len || conflict_exclusive !== e.c_excl ||
                    conflict_owner !== e.c_owner || holds_locks !== e.holds)
                begin
                    $display("%0t mismatch: expected st=%0d cs=%h cl=%h cx=%b co=%h hl=%b",
                             $realtime, e.st, e.c_start, e.c_len, e.c_excl, e.c_owner,
                             e.holds);
                    $display("%0t            actual st=%0d cs=%h cl=%h cx=%b co=%h hl=%b",
                             $realtime, status, conflict_start, conflict_length,
                             conflict_exclusive, conflict_owner, holds_locks);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_resps.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            lk_valid[i] = 1'b0;
        // Directed: extremes, every opcode, splits, conflicts, fill the table
        queue_req(make_req(OP_HAS_LOCKS, 32'd0, 32'd0, 1'b0, 64'd0, 64'd0));
        queue_req(make_req(OP_ACQUIRE, 32'd1, 32'd1, 1'b0, 64'd100, 64'd100));
        queue_req(make_req(OP_TEST, 32'd1, 32'd2, 1'b1, 64'd150, 64'd10));
        queue_req(make_req(OP_TEST, 32'd1, 32'd2, 1'b0, 64'd150, 64'd10));
        queue_req(make_req(OP_ACQUIRE, 32'd1, 32'd2, 1'b1, 64'd199, 64'd5));
        queue_req(make_req(OP_ACQUIRE, 32'd1, 32'd2, 1'b1, 64'd200, 64'd5));
        queue_req(make_req(OP_ACQUIRE, 32'd1, 32'd3, 1'b1, 64'd202, 64'd0));
        queue_req(make_req(OP_HAS_LOCKS, 32'd1, 32'd3, 1'b0, 64'd0, 64'd0));
        queue_req(make_req(OP_RELEASE, 32'd1, 32'd1, 1'b0, 64'd120, 64'd10));
        queue_req(make_req(OP_RELEASE, 32'd1, 32'd1, 1'b0, 64'd90, 64'd20));
        queue_req(make_req(OP_RELEASE, 32'd9, 32'd9, 1'b0, 64'd0, ALL_ONES));
        queue_req(make_req(OP_ACQUIRE, '1, '1, 1'b1, ALL_ONES - 5, 64'd100));
        queue_req(make_req(OP_ACQUIRE, '1, 32'd4, 1'b0, 64'd0, ALL_ONES));
        queue_req(make_req(OP_ACQUIRE, '1, 32'd5, 1'b0, 64'd10, ALL_ONES));
        queue_req(make_req(OP_RELEASE, '1, 32'd5, 1'b0, 64'd20, 64'd5));
        queue_req(make_req(OP_RELEASE, '1, 32'd4, 1'b0, 64'd50, ALL_ONES));
        queue_req(make_req(3'd6, '1, '1, 1'b1, ALL_ONES, ALL_ONES));
        queue_req(make_req(3'd7, 32'd1, 32'd1, 1'b0, 64'd1, 64'd1));
        queue_req(make_req(OP_REL_FILE, 32'd1, 32'd2, 1'b0, 64'd0, 64'd0));
        queue_req(make_req(OP_REL_OWNER, 32'd0, '1, 1'b0, 64'd0, 64'd0));
        // Fill the table with disjoint locks of one owner, then overflow it
        for (int i = 0; i < SLOTS + 2; i++)
            queue_req(make_req(OP_ACQUIRE, 32'd8, 32'd8, 1'b0,
                               64'd1000 * i, 64'd500));
        // Release that needs a split while the table is full, then clean up
        queue_req(make_req(OP_RELEASE, 32'd8, 32'd8, 1'b0, 64'd100, 64'd10));
        queue_req(make_req(OP_RELEASE, 32'd8, 32'd8, 1'b0, 64'd1100, 64'd10));
        queue_req(make_req(OP_REL_OWNER, 32'd0, 32'd8, 1'b0, 64'd0, 64'd0));

        // Random: mostly acquire/release traffic on a few files and owners
        for (int i = 0; i < RANDOM_ITEMS; i++)
            queue_req(random_req());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_resps.size() == 0);
        // Allow any stray result to show up
        repeat (4 * SLOTS * 3 + 20) @(posedge clk);
        $display("%0d items sent, %0d results checked", sent, received);
        $display("%0d conflicts, %0d table-full, %0d remnants split off",
                 n_conflict, n_full, n_split);
        if (errors == 0 && expected_resps.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
